// ===== src/irsgd_pkg.sv =====
// Shared constants and types for the IR swipe gesture detector.
package irsgd_pkg;

	localparam int WINDOW     = 8;
	localparam int SAMPLE_W   = 8;
	localparam int MIN_HITS_W = 7;
	localparam int HIT_W      = $clog2(WINDOW + 1);
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [SAMPLE_W-1:0]   THRESHOLD_RST = 8'd100;
	localparam logic [MIN_HITS_W-1:0] MIN_HITS_RST  = 7'd4;

	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_MIN_HITS  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic left_present;
		logic right_present;
		logic swipe_right;
		logic swipe_left;
	} result_t;

endpackage

// ===== src/irsgd_window.sv =====
// Sample window of one sensor side with the hit count and presence decision.
module irsgd_window
	import irsgd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic [SAMPLE_W-1:0]   threshold,
	input  logic [MIN_HITS_W-1:0] min_hits,
	output logic                  present
);

	logic [SAMPLE_W-1:0] win_q   [WINDOW];
	logic [SAMPLE_W-1:0] win_nxt [WINDOW];
	logic [WINDOW-1:0]   hit_vec;
	logic [HIT_W-1:0]    hits;

	// The decision is taken on the window as it stands after the new sample enters.
	always_comb begin
		for (int i = 0; i < WINDOW - 1; i++) begin
			win_nxt[i] = win_q[i+1];
		end
		win_nxt[WINDOW-1] = sample;
		for (int i = 0; i < WINDOW; i++) begin
			hit_vec[i] = (win_nxt[i] > threshold);
		end
	end

	always_comb begin
		hits = '0;
		for (int i = 0; i < WINDOW; i++) begin
			hits = hits + HIT_W'(hit_vec[i]);
		end
	end

	assign present = (MIN_HITS_W'(hits) >= min_hits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= win_nxt[i];
			end
		end
	end

endmodule

// ===== src/irsgd_tracker.sv =====
// Two-state swipe tracker: armed by one side, fired by the other.
module irsgd_tracker
	import irsgd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic arm_side,
	input  logic fire_side,
	output logic fire,
	output logic armed
);

	logic armed_q;
	logic armed_nxt;

	// Arming has priority; it is only possible from the disarmed state.
	always_comb begin
		armed_nxt = armed_q;
		fire      = 1'b0;
		if (arm_side && !armed_q) begin
			armed_nxt = 1'b1;
		end else if (fire_side && armed_q) begin
			armed_nxt = 1'b0;
			fire      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (accept) begin
			armed_q <= armed_nxt;
		end
	end

	assign armed = armed_q;

endmodule

// ===== src/ir_swipe_gesture_detector.sv =====
// IR swipe gesture detector: one left/right sample pair in, presence and swipe flags out.
// Usage: each accepted request carries one front-left and one front-right 8-bit sample.
// Every sample enters its side's window of the last 8 samples; a side is present when at
// least min_hits window entries exceed detect_threshold, checked against the register
// values at the time of the request. A right swipe fires when the left side armed the
// tracker on an earlier request and the right side is present now; a left swipe mirrors it.
// The block takes one request per clock cycle while the output is not stalled and delivers
// its result in the output register on the next cycle; the window update, hit count and
// tracker step all complete in the cycle of acceptance. Registers: 0x0 detect_threshold
// (reset 100), 0x4 min_hits (reset 4); write them only while no request is in flight.
module ir_swipe_gesture_detector
	import irsgd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   left_sample,
	input  logic [SAMPLE_W-1:0]   right_sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  left_present,
	output logic                  right_present,
	output logic                  swipe_right,
	output logic                  swipe_left
);

	logic [SAMPLE_W-1:0]   threshold_q;
	logic [MIN_HITS_W-1:0] min_hits_q;
	reg_idx_t              reg_idx;
	logic                  cfg_wr;
	logic                  accept;
	logic                  lp;
	logic                  rp;
	logic                  fire_right;
	logic                  fire_left;
	logic                  right_armed;
	logic                  left_armed;
	result_t               res_q;
	logic                  out_valid_q;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			min_hits_q  <= MIN_HITS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_THRESHOLD: threshold_q <= pwdata[SAMPLE_W-1:0];
				REG_MIN_HITS:  min_hits_q  <= pwdata[MIN_HITS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = PDATA_W'(threshold_q);
			REG_MIN_HITS:  prdata = PDATA_W'(min_hits_q);
			default:       prdata = '0;
		endcase
	end

	// The output register frees up as soon as its result is taken.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	irsgd_window u_left_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (left_sample),
		.threshold (threshold_q),
		.min_hits  (min_hits_q),
		.present   (lp)
	);

	irsgd_window u_right_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (right_sample),
		.threshold (threshold_q),
		.min_hits  (min_hits_q),
		.present   (rp)
	);

	irsgd_tracker u_right_trk (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.arm_side  (lp),
		.fire_side (rp),
		.fire      (fire_right),
		.armed     (right_armed)
	);

	irsgd_tracker u_left_trk (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.arm_side  (rp),
		.fire_side (lp),
		.fire      (fire_left),
		.armed     (left_armed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.left_present  <= lp;
			res_q.right_present <= rp;
			res_q.swipe_right   <= fire_right;
			res_q.swipe_left    <= fire_left;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_present  = res_q.left_present;
	assign right_present = res_q.right_present;
	assign swipe_right   = res_q.swipe_right;
	assign swipe_left    = res_q.swipe_left;

`ifndef SYNTHESIS
	// A swipe can only complete when the finishing side is present.
	a_right_needs_presence: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && swipe_right |-> right_present)
		else $error("swipe_right without right presence");

	a_left_needs_presence: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && swipe_left |-> left_present)
		else $error("swipe_left without left presence");

	// A fired tracker is disarmed while its result is on the output.
	a_right_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && swipe_right |-> !right_armed)
		else $error("right tracker still armed after firing");

	a_left_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && swipe_left |-> !left_armed)
		else $error("left tracker still armed after firing");
`endif

endmodule
